### rtl/aws_pkg.sv
// Shared types and constants of the audio waveshaper.
`default_nettype none
package aws_pkg;

  typedef enum logic [1:0] {
    MODE_RATIONAL = 2'd0,
    MODE_CUBIC    = 2'd1,
    MODE_TANH     = 2'd2,
    MODE_ATAN     = 2'd3
  } shaper_mode_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_IN_GAIN     = 3'd1,
    REG_OUT_GAIN    = 3'd2,
    REG_BIAS_BEFORE = 3'd3,
    REG_BIAS_AFTER  = 3'd4
  } reg_index_t;

  localparam int CURVE_FRAC    = 30;
  localparam int DIV_STAGES    = 16;
  localparam int CORDIC_STAGES = 15;
  localparam int TANH_SLOTS    = 8;
  localparam int CUBIC_STAGES  = 5;

  localparam logic [31:0] CURVE_ONE   = 32'h4000_0000;
  localparam logic [29:0] TANH_SCALE  = 30'd683565276;
  localparam logic [29:0] CUBIC_CLAMP = 30'd715827883;
  localparam logic [31:0] RECIP_3     = 32'd1431655766;
  localparam logic [31:0] RECIP_15    = 32'd286331154;
  localparam logic [31:0] RECIP_315   = 32'd13634817;
  localparam logic signed [15:0] BIAS_MAX = 16'sd16384;
  localparam logic signed [15:0] BIAS_MIN = -16'sd16384;

  localparam logic [31:0] ATAN_STEPS [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage
`default_nettype wire

### rtl/aws_div.sv
// Pipelined restoring fraction divider: floor(num * 2^30 / den), num <= den.
`default_nettype none
module aws_div #(
  parameter int NW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [30:0]   quo,
  output logic [TW-1:0] tag_out
);
  import aws_pkg::*;

  logic [NW:0]   rem_r [DIV_STAGES];
  logic [NW:0]   rem_nxt [DIV_STAGES];
  logic [30:0]   q_r [DIV_STAGES];
  logic [30:0]   q_nxt [DIV_STAGES];
  logic [NW-1:0] d_r [DIV_STAGES];
  logic [TW-1:0] tag_r [DIV_STAGES];

  always_comb begin
    logic [NW:0] rw;
    logic [30:0] qw;
    if ({1'b0, num} >= {1'b0, den}) begin
      rem_nxt[0] = {1'b0, num} - {1'b0, den};
      q_nxt[0]   = 31'd1;
    end else begin
      rem_nxt[0] = {1'b0, num};
      q_nxt[0]   = 31'd0;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      rw = rem_r[s-1];
      qw = q_r[s-1];
      for (int k = 0; k < 2; k++) begin
        rw = {rw[NW-1:0], 1'b0};
        qw = {qw[29:0], 1'b0};
        if (rw >= {1'b0, d_r[s-1]}) begin
          rw    = rw - {1'b0, d_r[s-1]};
          qw[0] = 1'b1;
        end
      end
      rem_nxt[s] = rw;
      q_nxt[s]   = qw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= den;
      tag_r[0] <= tag_in;
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        d_r[s]   <= d_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign quo     = q_r[DIV_STAGES-1];
  assign tag_out = tag_r[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/aws_atan.sv
// Pipelined vectoring CORDIC giving (2/pi)*atan(x) in Q30, two iterations per stage.
`default_nettype none
module aws_atan (
  input  logic               clk,
  input  logic               en,
  input  logic signed [35:0] xq,
  output logic signed [32:0] ang
);
  import aws_pkg::*;

  localparam int NS = CORDIC_STAGES + 1;

  logic signed [39:0] cx_r [NS];
  logic signed [39:0] cy_r [NS];
  logic signed [32:0] cz_r [NS];
  logic signed [39:0] cx_nxt [NS];
  logic signed [39:0] cy_nxt [NS];
  logic signed [32:0] cz_nxt [NS];

  always_comb begin
    logic signed [39:0] xw;
    logic signed [39:0] yw;
    logic signed [39:0] dx;
    logic signed [39:0] dy;
    logic signed [32:0] zw;
    cx_nxt[0] = 40'(CURVE_ONE);
    cy_nxt[0] = 40'(xq);
    cz_nxt[0] = '0;
    for (int s = 1; s < NS; s++) begin
      xw = cx_r[s-1];
      yw = cy_r[s-1];
      zw = cz_r[s-1];
      for (int k = 0; k < 2; k++) begin
        dx = yw >>> (2 * (s - 1) + k);
        dy = xw >>> (2 * (s - 1) + k);
        if (!yw[39]) begin
          xw = xw + dx;
          yw = yw - dy;
          zw = zw + $signed(33'(ATAN_STEPS[2 * (s - 1) + k]));
        end else begin
          xw = xw - dx;
          yw = yw + dy;
          zw = zw - $signed(33'(ATAN_STEPS[2 * (s - 1) + k]));
        end
      end
      cx_nxt[s] = xw;
      cy_nxt[s] = yw;
      cz_nxt[s] = zw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        cx_r[s] <= cx_nxt[s];
        cy_r[s] <= cy_nxt[s];
        cz_r[s] <= cz_nxt[s];
      end
    end
  end

  assign ang = cz_r[NS-1];

endmodule
`default_nettype wire

### rtl/audio_waveshaper_unit.sv
// Top level of the audio waveshaper: drive, four curves, makeup gain, APB registers.
// Throughput: one item per cycle when not stalled; the tanh lane (eight doubling
// steps, each a 16-stage divider) sets the pipeline depth.
// Backpressure freezes every stage at once; in_tready follows the output register.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults.
`default_nettype none
module audio_waveshaper_unit #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // sample_out
  output logic                                 out_tuser,  // saturated
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [4:0]                           cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import aws_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PW  = SB + 19;
  localparam int XW  = SB + 7;
  localparam int XSH = (SB <= 31) ? 31 - SB : 0;
  localparam int XSR = (SB > 31) ? SB - 31 : 0;
  localparam int OSH = 43 - SB;
  localparam int LS  = DIV_STAGES;
  localparam int LT  = 1 + 6 + TANH_SLOTS * (1 + DIV_STAGES) + 1;
  localparam logic signed [PW:0] DRV_RND = (PW + 1)'(8192);
  localparam logic signed [49:0] OUT_RND = 50'sd1 <<< (OSH - 1);

  // configuration
  shaper_mode_t       mode_r;
  logic signed [15:0] igain_r;
  logic signed [15:0] ogain_r;
  logic signed [15:0] bbef_r;
  logic signed [15:0] baft_r;
  logic signed [15:0] wr_val;
  logic signed [15:0] wr_clamp;
  logic               cfg_wr;
  reg_index_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_index_t'(cfg_paddr[4:2]);
  assign wr_val     = $signed(cfg_pwdata[15:0]);

  always_comb begin
    if (wr_val > BIAS_MAX) begin
      wr_clamp = BIAS_MAX;
    end else if (wr_val < BIAS_MIN) begin
      wr_clamp = BIAS_MIN;
    end else begin
      wr_clamp = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RATIONAL;
      igain_r <= 16'sd4096;
      ogain_r <= 16'sd4096;
      bbef_r  <= '0;
      baft_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:        mode_r  <= shaper_mode_t'(cfg_pwdata[1:0]);
        REG_IN_GAIN:     igain_r <= wr_val;
        REG_OUT_GAIN:    ogain_r <= wr_val;
        REG_BIAS_BEFORE: bbef_r  <= wr_clamp;
        REG_BIAS_AFTER:  baft_r  <= wr_clamp;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:        cfg_prdata = {30'd0, mode_r};
      REG_IN_GAIN:     cfg_prdata = 32'(igain_r);
      REG_OUT_GAIN:    cfg_prdata = 32'(ogain_r);
      REG_BIAS_BEFORE: cfg_prdata = 32'(bbef_r);
      REG_BIAS_AFTER:  cfg_prdata = 32'(baft_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // drive stage 1: gain product
  logic                 v1_r;
  shaper_mode_t         md1_r;
  logic signed [PW-1:0] p1_r;
  logic signed [18:0]   gain_c;
  logic signed [SB-1:0] smp_c;

  assign gain_c = (19'(igain_r) <<< 2) + 19'(bbef_r);
  assign smp_c  = $signed(in_tdata[SB-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md1_r <= mode_r;
      p1_r  <= PW'(gain_c) * PW'(smp_c);
    end
  end

  // drive stage 2: round, bias, saturate, move to Q30
  logic                 v2_r;
  shaper_mode_t         md2_r;
  logic                 sat2_r;
  logic                 neg2_r;
  logic signed [35:0]   xq2_r;
  logic [35:0]          m2_r;
  logic signed [PW:0]   xr_c;
  logic signed [SB:0]   ba_c;
  logic signed [XW-1:0] x_c;
  logic signed [SB+4:0] xs_c;
  logic signed [36:0]   xw_c;
  logic signed [35:0]   xq_c;
  logic                 dsat_c;

  always_comb begin
    xr_c   = ((PW + 1)'(p1_r) + DRV_RND) >>> 14;
    ba_c   = (SB + 1)'(baft_r) <<< (SB - 15);
    x_c    = XW'(xr_c) + XW'(ba_c);
    dsat_c = !((&x_c[XW-1:SB+4]) || !(|x_c[XW-1:SB+4]));
    if (dsat_c) begin
      xs_c = x_c[XW-1] ? {1'b1, {(SB + 4){1'b0}}} : {1'b0, {(SB + 4){1'b1}}};
    end else begin
      xs_c = x_c[SB+4:0];
    end
    xw_c = 37'(xs_c);
    xq_c = 36'((xw_c <<< XSH) >>> XSR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md2_r  <= md1_r;
      sat2_r <= dsat_c;
      neg2_r <= xq_c[35];
      xq2_r  <= xq_c;
      m2_r   <= xq_c[35] ? 36'(-xq_c) : 36'(xq_c);
    end
  end

  // rational lane
  logic [30:0] rat_q;
  logic        rat_tag;

  aws_div #(.NW(37), .TW(1)) u_rat_div (
    .clk     (clk),
    .en      (en),
    .num     ({1'b0, m2_r}),
    .den     (37'(m2_r) + 37'(CURVE_ONE)),
    .tag_in  (1'b0),
    .quo     (rat_q),
    .tag_out (rat_tag)
  );

  // arctangent lane
  logic signed [32:0] atan_z;

  aws_atan u_atan (
    .clk (clk),
    .en  (en),
    .xq  (xq2_r),
    .ang (atan_z)
  );

  // cubic lane
  logic               c1_cl_r, c2_cl_r, c3_cl_r, c4_cl_r;
  logic               c1_ng_r, c2_ng_r, c3_ng_r, c4_ng_r;
  logic [30:0]        c1_a_r, c2_a_r, c3_a_r, c4_a_r;
  logic [30:0]        c1_x2_r;
  logic [61:0]        c2_p_r;
  logic [30:0]        c3_m3_r;
  logic [62:0]        c4_qd_r;
  logic signed [32:0] c5_y_r;
  logic signed [32:0] cpad_r [LS-CUBIC_STAGES];
  logic [61:0]        c_sq;
  logic [30:0]        c_mag;
  logic [32:0]        c_abs;

  assign c_sq  = 62'(m2_r[30:0]) * 62'(m2_r[30:0]);
  assign c_mag = c4_a_r - 31'(c4_qd_r >> 32);
  assign c_abs = c4_cl_r ? 33'(CUBIC_CLAMP) : 33'(c_mag);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_cl_r <= m2_r > 36'(CURVE_ONE);
      c1_ng_r <= neg2_r;
      c1_a_r  <= m2_r[30:0];
      c1_x2_r <= 31'(c_sq >> CURVE_FRAC);
      c2_cl_r <= c1_cl_r;
      c2_ng_r <= c1_ng_r;
      c2_a_r  <= c1_a_r;
      c2_p_r  <= 62'(c1_x2_r) * 62'(c1_a_r);
      c3_cl_r <= c2_cl_r;
      c3_ng_r <= c2_ng_r;
      c3_a_r  <= c2_a_r;
      c3_m3_r <= c2_ng_r ? 31'((63'(c2_p_r) + 63'(CURVE_ONE - 32'd1)) >> CURVE_FRAC)
                         : 31'(c2_p_r >> CURVE_FRAC);
      c4_cl_r <= c3_cl_r;
      c4_ng_r <= c3_ng_r;
      c4_a_r  <= c3_a_r;
      c4_qd_r <= 63'(c3_m3_r) * 63'(RECIP_3);
      c5_y_r  <= c4_ng_r ? -$signed(c_abs) : $signed(c_abs);
      cpad_r[0] <= c5_y_r;
      for (int i = 1; i < LS - CUBIC_STAGES; i++) begin
        cpad_r[i] <= cpad_r[i-1];
      end
    end
  end

  // tanh lane: range reduction
  logic [3:0]  tk_c;
  logic [27:0] ta_c;

  always_comb begin
    tk_c = '0;
    for (int j = 0; j < TANH_SLOTS; j++) begin
      if ((m2_r >> j) > 36'(CURVE_ONE >> 3)) begin
        tk_c = tk_c + 4'd1;
      end
    end
    ta_c = 28'(m2_r >> tk_c);
  end

  // tanh lane: odd series to the seventh power
  logic [27:0] ta_r [6];
  logic [3:0]  tk_r [7];
  logic [24:0] a2_r, a2b_r, a2c_r;
  logic [21:0] a3_r;
  logic [15:0] a5_r;
  logic [9:0]  a7_r;
  logic [20:0] q3_r, q3b_r, q3c_r;
  logic [12:0] q15_r, q15b_r;
  logic [4:0]  q315_r;
  logic [30:0] tt_r;
  logic [55:0] t_sq;
  logic [52:0] t_a3;
  logic [46:0] t_a5;
  logic [40:0] t_a7;
  logic [53:0] t_q3;
  logic [48:0] t_q15;
  logic [13:0] t_17a7;
  logic [45:0] t_q315;
  logic [31:0] t_sum;

  always_comb begin
    t_sq   = 56'(ta_r[0]) * 56'(ta_r[0]);
    t_a3   = 53'(a2_r) * 53'(ta_r[1]);
    t_a5   = 47'(a3_r) * 47'(a2b_r);
    t_q3   = 54'(a3_r) * 54'(RECIP_3);
    t_a7   = 41'(a5_r) * 41'(a2c_r);
    t_q15  = 49'({a5_r, 1'b0}) * 49'(RECIP_15);
    t_17a7 = {a7_r, 4'd0} + 14'(a7_r);
    t_q315 = 46'(t_17a7) * 46'(RECIP_315);
    t_sum  = 32'(ta_r[5]) + 32'(q15b_r) - 32'(q3c_r) - 32'(q315_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r[0] <= ta_c;
      tk_r[0] <= tk_c;
      for (int i = 1; i < 6; i++) begin
        ta_r[i] <= ta_r[i-1];
      end
      for (int i = 1; i < 7; i++) begin
        tk_r[i] <= tk_r[i-1];
      end
      a2_r   <= 25'(t_sq >> CURVE_FRAC);
      a2b_r  <= a2_r;
      a3_r   <= 22'(t_a3 >> CURVE_FRAC);
      a2c_r  <= a2b_r;
      a5_r   <= 16'(t_a5 >> CURVE_FRAC);
      q3_r   <= 21'(t_q3 >> 32);
      q3b_r  <= q3_r;
      a7_r   <= 10'(t_a7 >> CURVE_FRAC);
      q15_r  <= 13'(t_q15 >> 32);
      q3c_r  <= q3b_r;
      q15b_r <= q15_r;
      q315_r <= 5'(t_q315 >> 32);
      tt_r   <= 31'(t_sum);
    end
  end

  // tanh lane: doubling steps t = 2t / (1 + t^2)
  logic [30:0] sl_t [TANH_SLOTS+1];
  logic [3:0]  sl_k [TANH_SLOTS+1];

  assign sl_t[0] = tt_r;
  assign sl_k[0] = tk_r[6];

  for (genvar j = 0; j < TANH_SLOTS; j++) begin : g_dbl
    logic [30:0] mt_r;
    logic [3:0]  mk_r;
    logic [30:0] mt2_r;
    logic [61:0] sq;
    logic [30:0] dq;
    logic [30:0] dt;
    logic [3:0]  dk;

    assign sq = 62'(sl_t[j]) * 62'(sl_t[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        mt_r  <= sl_t[j];
        mk_r  <= sl_k[j];
        mt2_r <= 31'(sq >> CURVE_FRAC);
      end
    end

    aws_div #(.NW(32), .TW(35)) u_dbl_div (
      .clk     (clk),
      .en      (en),
      .num     ({mt_r, 1'b0}),
      .den     (CURVE_ONE + 32'(mt2_r)),
      .tag_in  ({mt_r, mk_r}),
      .quo     (dq),
      .tag_out ({dt, dk})
    );

    assign sl_t[j+1] = (4'(j) < dk) ? dq : dt;
    assign sl_k[j+1] = dk;
  end

  logic [29:0] tym_r;
  logic [60:0] t_fin;

  assign t_fin = 61'(sl_t[TANH_SLOTS]) * 61'(TANH_SCALE);

  always_ff @(posedge clk) begin
    if (en) begin
      tym_r <= 30'(t_fin >> CURVE_FRAC);
    end
  end

  // item delay line and short-lane result
  logic               lv_r [LT];
  shaper_mode_t       lmd_r [LT];
  logic               lsat_r [LT];
  logic               lneg_r [LT];
  logic signed [32:0] ysl_r [LT-LS];
  logic signed [32:0] ys_c;

  always_comb begin
    case (lmd_r[LS-1])
      MODE_RATIONAL: ys_c = lneg_r[LS-1] ? -$signed(33'(rat_q)) : $signed(33'(rat_q));
      MODE_CUBIC:    ys_c = cpad_r[LS-CUBIC_STAGES-1];
      MODE_ATAN:     ys_c = atan_z;
      default:       ys_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LT; i++) begin
        lv_r[i] <= 1'b0;
      end
    end else if (en) begin
      lv_r[0] <= v2_r;
      for (int i = 1; i < LT; i++) begin
        lv_r[i] <= lv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lmd_r[0]  <= md2_r;
      lsat_r[0] <= sat2_r;
      lneg_r[0] <= neg2_r;
      for (int i = 1; i < LT; i++) begin
        lmd_r[i]  <= lmd_r[i-1];
        lsat_r[i] <= lsat_r[i-1];
        lneg_r[i] <= lneg_r[i-1];
      end
      ysl_r[0] <= ys_c;
      for (int i = 1; i < LT - LS; i++) begin
        ysl_r[i] <= ysl_r[i-1];
      end
    end
  end

  // makeup gain
  logic               vo_r;
  logic               sato_r;
  logic signed [48:0] prod_r;
  logic signed [32:0] ysel_c;

  always_comb begin
    if (lmd_r[LT-1] == MODE_TANH) begin
      ysel_c = lneg_r[LT-1] ? -$signed(33'(tym_r)) : $signed(33'(tym_r));
    end else begin
      ysel_c = ysl_r[LT-LS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= lv_r[LT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sato_r <= lsat_r[LT-1];
      prod_r <= 49'(ysel_c) * 49'(ogain_r);
    end
  end

  // round, saturate, output register
  logic signed [49:0] o_c;
  logic               osat_c;
  logic [SB-1:0]      osmp_c;
  logic [SB-1:0]      out_smp_r;
  logic               out_sat_r;

  always_comb begin
    o_c    = (50'(prod_r) + OUT_RND) >>> OSH;
    osat_c = !((&o_c[49:SB-1]) || !(|o_c[49:SB-1]));
    if (osat_c) begin
      osmp_c = o_c[49] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
    end else begin
      osmp_c = o_c[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_smp_r <= osmp_c;
      out_sat_r <= sato_r || osat_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DW'(out_smp_r);
  assign out_tuser  = out_sat_r;

endmodule
`default_nettype wire
